@@ hdl/osmc_pkg.sv @@
// Package: shared types and constants for the obstacle-stop mode controller.
package osmc_pkg;

  localparam int DistW  = 16;
  localparam int CountW = 4;
  localparam int CmdW   = 3;
  localparam int CfgIdxW = 3;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [DistW-1:0]  StopDistRst   = 16'd180;
  localparam logic [DistW-1:0]  ClearDistRst  = 16'd230;
  localparam logic [CountW-1:0] ConfirmNeedRst = 4'd3;
  localparam logic [CountW-1:0] ClearNeedRst  = 4'd2;
  localparam logic [DistW-1:0]  ReportDeltaRst = 16'd10;

  typedef enum logic [1:0] {
    MODE_MANUAL   = 2'd0,
    MODE_TRACKING = 2'd1,
    MODE_OBSTACLE = 2'd2,
    MODE_WAIT     = 2'd3
  } mode_t;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_TRACK_ON   = 3'd1,
    CMD_MANUAL     = 3'd2,
    CMD_CONTINUE   = 3'd3,
    CMD_HOLD       = 3'd4,
    CMD_TRACK_HOLD = 3'd5
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STOP_DIST    = 3'd0,
    REG_CLEAR_DIST   = 3'd1,
    REG_CONFIRM_NEED = 3'd2,
    REG_CLEAR_NEED   = 3'd3,
    REG_REPORT_DELTA = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DistW-1:0]  stop_distance;
    logic [DistW-1:0]  clear_distance;
    logic [CountW-1:0] confirm_needed;
    logic [CountW-1:0] clear_needed;
    logic [DistW-1:0]  report_delta;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [CountW-1:0] confirm_cnt;
    logic [CountW-1:0] clear_cnt;
    logic [DistW-1:0]  last_dist;
    logic              last_dist_known;
    logic [2:0]        last_line;
    logic              last_line_known;
  } state_t;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DistW-1:0] range_mm;
    logic             line_left;
    logic             line_mid;
    logic             line_right;
  } item_t;

  typedef struct packed {
    mode_t            mode;
    logic             force_stop;
    logic             distance_report_valid;
    logic [DistW-1:0] distance_report;
    logic             line_report_valid;
    logic             report_left;
    logic             report_mid;
    logic             report_right;
    logic             obstacle_event;
    logic [DistW-1:0] obstacle_distance;
    logic             clear_event;
    logic             error;
  } result_t;

endpackage

@@ hdl/osmc_if.sv @@
// Interfaces: input item channel and result channel with valid/ready handshake.
interface osmc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] range_mm;
  logic        line_left;
  logic        line_mid;
  logic        line_right;

  modport source (output valid, cmd, range_mm, line_left, line_mid, line_right,
                  input ready);
  modport sink   (input valid, cmd, range_mm, line_left, line_mid, line_right,
                  output ready);
endinterface

interface osmc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        force_stop;
  logic        distance_report_valid;
  logic [15:0] distance_report;
  logic        line_report_valid;
  logic        report_left;
  logic        report_mid;
  logic        report_right;
  logic        obstacle_event;
  logic [15:0] obstacle_distance;
  logic        clear_event;
  logic        error;

  modport source (output valid, mode, force_stop, distance_report_valid, distance_report,
                  line_report_valid, report_left, report_mid, report_right,
                  obstacle_event, obstacle_distance, clear_event, error,
                  input ready);
  modport sink   (input valid, mode, force_stop, distance_report_valid, distance_report,
                  line_report_valid, report_left, report_mid, report_right,
                  obstacle_event, obstacle_distance, clear_event, error,
                  output ready);
endinterface

@@ hdl/osmc_step.sv @@
// Step logic: next controller state and result for one item.
module osmc_step (
  input  osmc_pkg::cfg_t    cfg,
  input  osmc_pkg::state_t  st,
  input  osmc_pkg::item_t   item,
  output osmc_pkg::state_t  st_nxt,
  output osmc_pkg::result_t res
);
  import osmc_pkg::*;

  logic [CountW-1:0] conf_base;
  logic [CountW-1:0] clr_base;
  logic [CountW-1:0] conf_inc;
  logic [CountW-1:0] clr_inc;
  logic [DistW-1:0]  gap;
  logic [2:0]        bits;
  logic              dist_zero;
  logic              active;
  logic              dist_rep;
  logic              line_rep;

  always_comb begin
    // Counter housekeeping done before the command is applied
    conf_base = (st.mode != MODE_TRACKING) ? '0 : st.confirm_cnt;
    clr_base  = (st.mode == MODE_MANUAL || st.mode == MODE_WAIT) ? '0 : st.clear_cnt;
    conf_inc  = (conf_base == CountMax) ? CountMax : conf_base + 1'b1;
    clr_inc   = (clr_base == CountMax) ? CountMax : clr_base + 1'b1;
    gap       = (item.range_mm >= st.last_dist) ? item.range_mm - st.last_dist
                                                : st.last_dist - item.range_mm;
    bits      = {item.line_left, item.line_mid, item.line_right};
    dist_zero = (item.range_mm == '0);
    active    = (st.mode == MODE_TRACKING) || (st.mode == MODE_OBSTACLE);
    dist_rep  = !st.last_dist_known || dist_zero || (st.last_dist == '0) ||
                (gap >= cfg.report_delta);
    line_rep  = !st.last_line_known || (bits != st.last_line);

    st_nxt             = st;
    st_nxt.confirm_cnt = conf_base;
    st_nxt.clear_cnt   = clr_base;
    res                = '0;

    case (cmd_t'(item.cmd))
      CMD_SAMPLE: begin
        if (active) begin
          if (dist_rep) begin
            res.distance_report_valid = 1'b1;
            res.distance_report       = item.range_mm;
            st_nxt.last_dist          = item.range_mm;
            st_nxt.last_dist_known    = 1'b1;
          end
          if (line_rep) begin
            res.line_report_valid  = 1'b1;
            res.report_left        = item.line_left;
            res.report_mid         = item.line_mid;
            res.report_right       = item.line_right;
            st_nxt.last_line       = bits;
            st_nxt.last_line_known = 1'b1;
          end
          if (st.mode == MODE_OBSTACLE) begin
            res.force_stop = 1'b1;
            if (dist_zero || item.range_mm >= cfg.clear_distance) begin
              // a needed count of zero behaves as one since clr_inc is never zero
              if (clr_inc >= cfg.clear_needed) begin
                st_nxt.mode        = MODE_TRACKING;
                st_nxt.confirm_cnt = '0;
                st_nxt.clear_cnt   = '0;
                res.clear_event    = 1'b1;
              end else begin
                st_nxt.clear_cnt = clr_inc;
              end
            end else begin
              st_nxt.clear_cnt = '0;
            end
          end else if (!dist_zero && item.range_mm <= cfg.stop_distance) begin
            if (conf_inc >= cfg.confirm_needed) begin
              st_nxt.mode           = MODE_OBSTACLE;
              st_nxt.confirm_cnt    = '0;
              st_nxt.clear_cnt      = '0;
              res.force_stop        = 1'b1;
              res.obstacle_event    = 1'b1;
              res.obstacle_distance = item.range_mm;
            end else begin
              st_nxt.confirm_cnt = conf_inc;
            end
          end else begin
            st_nxt.confirm_cnt = '0;
            st_nxt.clear_cnt   = '0;
          end
        end
      end
      CMD_TRACK_ON: begin
        st_nxt.mode        = MODE_TRACKING;
        st_nxt.confirm_cnt = '0;
        st_nxt.clear_cnt   = '0;
      end
      CMD_MANUAL: begin
        st_nxt.mode = MODE_MANUAL;
      end
      CMD_CONTINUE: begin
        if (st.mode == MODE_WAIT) begin
          st_nxt.mode        = MODE_TRACKING;
          st_nxt.confirm_cnt = '0;
          st_nxt.clear_cnt   = '0;
        end else begin
          res.error = 1'b1;
        end
      end
      CMD_HOLD: begin
        st_nxt.mode    = MODE_WAIT;
        res.force_stop = 1'b1;
      end
      CMD_TRACK_HOLD: begin
        if (st.mode == MODE_TRACKING) begin
          st_nxt.mode    = MODE_WAIT;
          res.force_stop = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.mode = st_nxt.mode;
  end

endmodule

@@ hdl/obstacle_stop_mode_controller_core.sv @@
// Top level: obstacle-stop mode controller with input and result registers.
// Path: an input transfer loads the input register; the step logic then loads the
// result register and updates the controller state once the result side has room.
// Throughput: one item per cycle unless stalled; the state update loops through the
// step logic. Stalls on the result side back up through the two registers.
// Reset (rst_n low, synchronous): manual mode, counters and report history cleared,
// configuration registers back to their defaults, both stages empty.
module obstacle_stop_mode_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  osmc_in_if.sink                        in_ch,
  osmc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [osmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [osmc_pkg::DistW-1:0]     cfg_wdata
);
  import osmc_pkg::*;

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_xfer;

  assign advance     = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  osmc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_distance  <= StopDistRst;
      cfg_r.clear_distance <= ClearDistRst;
      cfg_r.confirm_needed <= ConfirmNeedRst;
      cfg_r.clear_needed   <= ClearNeedRst;
      cfg_r.report_delta   <= ReportDeltaRst;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_STOP_DIST:    cfg_r.stop_distance  <= cfg_wdata;
        REG_CLEAR_DIST:   cfg_r.clear_distance <= cfg_wdata;
        REG_CONFIRM_NEED: cfg_r.confirm_needed <= cfg_wdata[CountW-1:0];
        REG_CLEAR_NEED:   cfg_r.clear_needed   <= cfg_wdata[CountW-1:0];
        REG_REPORT_DELTA: cfg_r.report_delta   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.cmd        <= in_ch.cmd;
      item_r.range_mm   <= in_ch.range_mm;
      item_r.line_left  <= in_ch.line_left;
      item_r.line_mid   <= in_ch.line_mid;
      item_r.line_right <= in_ch.line_right;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.mode                  = res_r.mode;
  assign out_ch.force_stop            = res_r.force_stop;
  assign out_ch.distance_report_valid = res_r.distance_report_valid;
  assign out_ch.distance_report       = res_r.distance_report;
  assign out_ch.line_report_valid     = res_r.line_report_valid;
  assign out_ch.report_left           = res_r.report_left;
  assign out_ch.report_mid            = res_r.report_mid;
  assign out_ch.report_right          = res_r.report_right;
  assign out_ch.obstacle_event        = res_r.obstacle_event;
  assign out_ch.obstacle_distance     = res_r.obstacle_distance;
  assign out_ch.clear_event           = res_r.clear_event;
  assign out_ch.error                 = res_r.error;

endmodule
